### hw/rtl/tts_pkg.sv
// Shared types and constants for the text terminal with scrollback.
// Holds the request and response beat structs, request codes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

    // Default geometry
    localparam int SCREEN_COLS_DEF      = 80;
    localparam int SCREEN_ROWS_DEF      = 25;
    localparam int SCROLLBACK_LINES_DEF = 500;
    localparam int TAB_STOP_DEF         = 4;

    // Fixed field widths
    localparam int COL_W  = 7;
    localparam int LINE_W = 9;
    localparam int LU_W   = 10;
    localparam int TAB_W  = 5;

    // Request codes
    localparam logic [3:0] REQ_PUTCHAR  = 4'd0;
    localparam logic [3:0] REQ_SCR_UP   = 4'd1;
    localparam logic [3:0] REQ_SCR_DOWN = 4'd2;
    localparam logic [3:0] REQ_PAGE_UP  = 4'd3;
    localparam logic [3:0] REQ_PAGE_DN  = 4'd4;
    localparam logic [3:0] REQ_CLEAR    = 4'd5;
    localparam logic [3:0] REQ_SET_CUR  = 4'd6;
    localparam logic [3:0] REQ_PUT_AT   = 4'd7;
    localparam logic [3:0] REQ_READ     = 4'd8;

    // Configuration register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;

    // Cell value after reset and color defaults
    localparam logic [15:0] CELL_RESET = 16'h0720;
    localparam logic [3:0]  FG_RESET   = 4'd7;
    localparam logic [3:0]  BG_RESET   = 4'd0;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  cell_color;
        logic [6:0]  pos_x;
        logic [8:0]  pos_y;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [8:0]  cursor_row;
        logic [8:0]  view_top;
        logic [8:0]  line_count;
    } rsp_t;

endpackage

### hw/rtl/text_terminal_scrollback.sv
// Character terminal with a ring-organized scrollback store in one memory.
// Depends on tts_pkg for beat structs, request codes and defaults.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request beat; the
//   block raises req_stall while it works on a request. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one beat per request with
//   the read cell and the cursor / view / line count after the request.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata) sets the
//   foreground (index 0) and background (index 1) colors; always ready.
//   Scroll, page, cursor, carriage return and unused codes go straight to
//   the response; a cell write, a read and a printable character pass row
//   mapping, address multiply and memory access.
//   A line feed clears one to three rows (one cell per cycle through the
//   single memory port); a wrap clears rows the same way. A tab writes one
//   space after another up to the next tab stop. Clear writes every cell.
//   The response beat becomes valid in the same cycle that the next request
//   can be taken.
//   After reset a sweep fills the store with 0x0720; no request is taken
//   until the sweep ends.
//   A stalled response holds in the output register; the next request is
//   taken meanwhile and its response waits until the register frees.
`timescale 1ns / 1ps

module text_terminal_scrollback #(
    parameter int SCREEN_COLS      = tts_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS      = tts_pkg::SCREEN_ROWS_DEF,
    parameter int SCROLLBACK_LINES = tts_pkg::SCROLLBACK_LINES_DEF,
    parameter int TAB_STOP         = tts_pkg::TAB_STOP_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tts_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tts_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [3:0]    cfg_wdata
);

    localparam int DEPTH  = SCROLLBACK_LINES * SCREEN_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = tts_pkg::COL_W;
    localparam int LINE_W = tts_pkg::LINE_W;
    localparam int LU_W   = tts_pkg::LU_W;
    localparam int TAB_W  = tts_pkg::TAB_W;

    // State codes
    localparam logic [3:0] S_SWEEP    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_PHYS     = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_PRINT    = 4'd4;
    localparam logic [3:0] S_PRINT_WR = 4'd5;
    localparam logic [3:0] S_WRITE    = 4'd6;
    localparam logic [3:0] S_RD       = 4'd7;
    localparam logic [3:0] S_RD_WAIT  = 4'd8;
    localparam logic [3:0] S_ADV      = 4'd9;
    localparam logic [3:0] S_ADV_BLK  = 4'd10;
    localparam logic [3:0] S_BLANK    = 4'd11;
    localparam logic [3:0] S_NEXT     = 4'd12;
    localparam logic [3:0] S_PUSH     = 4'd13;

    // Tab room table: spaces to the next tab stop for each column
    function automatic logic [128*TAB_W-1:0] tab_rooms();
        logic [128*TAB_W-1:0] tbl;
        int r;
        tbl = '0;
        r = 0;
        for (int i = 0; i < 128; i++) begin
            tbl[i*TAB_W +: TAB_W] = TAB_W'(TAB_STOP - r);
            r = r + 1;
            if (r == TAB_STOP) begin
                r = 0;
            end
        end
        return tbl;
    endfunction

    localparam logic [128*TAB_W-1:0] TAB_ROOM = tab_rooms();

    function automatic logic [LINE_W-1:0] bottom_of(input logic [LU_W-1:0] lu);
        return (lu > LU_W'(SCREEN_ROWS)) ? LINE_W'(lu - LU_W'(SCREEN_ROWS)) : '0;
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] cl_reg, cl_next;
    logic [LU_W-1:0]   lu_reg, lu_next;
    logic [LINE_W-1:0] vo_reg, vo_next;
    logic [LINE_W-1:0] base_reg, base_next;
    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic [LINE_W-1:0] tgt_line_reg, tgt_line_next;
    logic [COL_W-1:0]  tgt_col_reg, tgt_col_next;
    logic [LINE_W-1:0] phys_reg, phys_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [3:0]        ret_reg, ret_next;
    logic [7:0]        pch_reg, pch_next;
    logic [15:0]       wcell_reg, wcell_next;
    logic [TAB_W-1:0]  tab_left_reg, tab_left_next;
    logic [1:0]        blank_left_reg, blank_left_next;
    logic [COL_W-1:0]  cnt_reg, cnt_next;
    logic              sweep_init_reg, sweep_init_next;
    logic [15:0]       cell_reg, cell_next;
    logic              rsp_valid_reg, rsp_valid_next;
    tts_pkg::rsp_t     rsp_reg, rsp_next;

    logic [15:0]       mem [DEPTH];
    logic [15:0]       rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [15:0]       mem_wdata;

    logic [15:0]       blank_cell;
    logic [7:0]        attr;
    logic [LINE_W:0]   phys_sum;
    logic [LU_W-1:0]   adv_lu;
    logic [LINE_W-1:0] adv_cl;
    logic [1:0]        adv_k;
    logic [LINE_W:0]   base_sum;
    logic [LU_W-1:0]   set_lu;
    logic [LU_W-1:0]   src_line;
    logic [LU_W-1:0]   page_dn;
    logic [LINE_W-1:0] bot;
    logic              x_ok;
    logic              y_ok;

    assign attr       = {bg_reg, fg_reg};
    assign blank_cell = {attr, tts_pkg::CH_SPACE};
    assign bot        = bottom_of(lu_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Line advance: up to two drops of the oldest line, then the cursor moves
    always_comb
    begin
        adv_lu = lu_reg;
        adv_cl = cl_reg;
        adv_k  = 2'd0;
        if (lu_reg >= LU_W'(SCROLLBACK_LINES))
        begin
            adv_k = 2'd1;
            if (adv_lu != '0) adv_lu = adv_lu - 1'b1;
            if (adv_cl != '0) adv_cl = adv_cl - 1'b1;
        end
        if (LU_W'(adv_cl) + 1'b1 >= LU_W'(SCROLLBACK_LINES))
        begin
            adv_k = adv_k + 1'b1;
            if (adv_lu != '0) adv_lu = adv_lu - 1'b1;
            if (adv_cl != '0) adv_cl = adv_cl - 1'b1;
        end
        else
        begin
            adv_cl = adv_cl + 1'b1;
        end
        if (LU_W'(adv_cl) + 1'b1 > adv_lu)
        begin
            adv_lu = LU_W'(adv_cl) + 1'b1;
        end
        base_sum = {1'b0, base_reg} + (LINE_W + 1)'(adv_k);
        if (base_sum >= (LINE_W + 1)'(SCROLLBACK_LINES))
        begin
            base_sum = base_sum - (LINE_W + 1)'(SCROLLBACK_LINES);
        end
    end

    // Helpers for request decode and row mapping
    always_comb
    begin
        phys_sum = {1'b0, base_reg} + {1'b0, tgt_line_reg};
        if (phys_sum >= (LINE_W + 1)'(SCROLLBACK_LINES))
        begin
            phys_sum = phys_sum - (LINE_W + 1)'(SCROLLBACK_LINES);
        end
        set_lu   = (lu_reg <= LU_W'(req.pos_y)) ? LU_W'(req.pos_y) + 1'b1 : lu_reg;
        src_line = LU_W'(vo_reg) + LU_W'(req.pos_y);
        page_dn  = LU_W'(vo_reg) + LU_W'(SCREEN_ROWS);
        x_ok     = ((COL_W + 1)'(req.pos_x) < (COL_W + 1)'(SCREEN_COLS));
        y_ok     = (LU_W'(req.pos_y) < LU_W'(SCROLLBACK_LINES));
    end

    // Control sequencer
    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        cl_next         = cl_reg;
        lu_next         = lu_reg;
        vo_next         = vo_reg;
        base_next       = base_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        tgt_line_next   = tgt_line_reg;
        tgt_col_next    = tgt_col_reg;
        phys_next       = phys_reg;
        addr_next       = addr_reg;
        ret_next        = ret_reg;
        pch_next        = pch_reg;
        wcell_next      = wcell_reg;
        tab_left_next   = tab_left_reg;
        blank_left_next = blank_left_reg;
        cnt_next        = cnt_reg;
        sweep_init_next = sweep_init_reg;
        cell_next       = cell_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = wcell_reg;

        // Response register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // Color registers
        if (cfg_valid)
        begin
            if (cfg_index == tts_pkg::CFG_FG) fg_next = cfg_wdata;
            else                              bg_next = cfg_wdata;
        end

        case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = sweep_init_reg ? tts_pkg::CELL_RESET : blank_cell;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    addr_next  = '0;
                    state_next = sweep_init_reg ? S_IDLE : S_PUSH;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cell_next  = '0;
                    state_next = S_PUSH;
                    case (req.req_type)
                        tts_pkg::REQ_PUTCHAR:
                        begin
                            tab_left_next = TAB_W'(1);
                            pch_next      = req.char_code;
                            if (req.char_code == tts_pkg::CH_LF)
                            begin
                                col_next   = '0;
                                state_next = S_ADV;
                            end
                            else if (req.char_code == tts_pkg::CH_CR)
                            begin
                                col_next = '0;
                            end
                            else if (req.char_code == tts_pkg::CH_TAB)
                            begin
                                pch_next      = tts_pkg::CH_SPACE;
                                tab_left_next = TAB_ROOM[col_reg*TAB_W +: TAB_W];
                                state_next    = S_PRINT;
                            end
                            else if (req.char_code == tts_pkg::CH_BS)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next      = col_reg - 1'b1;
                                    tgt_line_next = cl_reg;
                                    tgt_col_next  = col_reg - 1'b1;
                                    wcell_next    = blank_cell;
                                    ret_next      = S_WRITE;
                                    state_next    = S_PHYS;
                                end
                            end
                            else
                            begin
                                state_next = S_PRINT;
                            end
                        end
                        tts_pkg::REQ_SCR_UP:
                        begin
                            if (vo_reg != '0) vo_next = vo_reg - 1'b1;
                        end
                        tts_pkg::REQ_SCR_DOWN:
                        begin
                            if (vo_reg < bot) vo_next = vo_reg + 1'b1;
                        end
                        tts_pkg::REQ_PAGE_UP:
                        begin
                            vo_next = (vo_reg > LINE_W'(SCREEN_ROWS)) ?
                                      vo_reg - LINE_W'(SCREEN_ROWS) : '0;
                        end
                        tts_pkg::REQ_PAGE_DN:
                        begin
                            vo_next = (page_dn < LU_W'(bot)) ? LINE_W'(page_dn) : bot;
                        end
                        tts_pkg::REQ_CLEAR:
                        begin
                            col_next        = '0;
                            cl_next         = '0;
                            lu_next         = LU_W'(1);
                            vo_next         = '0;
                            base_next       = '0;
                            addr_next       = '0;
                            sweep_init_next = 1'b0;
                            state_next      = S_SWEEP;
                        end
                        tts_pkg::REQ_SET_CUR:
                        begin
                            if (x_ok) col_next = req.pos_x;
                            if (y_ok)
                            begin
                                cl_next = req.pos_y;
                                lu_next = set_lu;
                                vo_next = bottom_of(set_lu);
                            end
                        end
                        tts_pkg::REQ_PUT_AT:
                        begin
                            if (x_ok && y_ok)
                            begin
                                lu_next       = set_lu;
                                tgt_line_next = req.pos_y;
                                tgt_col_next  = req.pos_x;
                                wcell_next    = {req.cell_color, req.char_code};
                                ret_next      = S_WRITE;
                                state_next    = S_PHYS;
                            end
                        end
                        tts_pkg::REQ_READ:
                        begin
                            if (x_ok && req.pos_y < LINE_W'(SCREEN_ROWS))
                            begin
                                if (src_line < lu_reg)
                                begin
                                    tgt_line_next = LINE_W'(src_line);
                                    tgt_col_next  = req.pos_x;
                                    ret_next      = S_RD;
                                    state_next    = S_PHYS;
                                end
                                else
                                begin
                                    cell_next = blank_cell;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end
            // Logical line to ring row
            S_PHYS:
            begin
                phys_next  = LINE_W'(phys_sum);
                state_next = S_MUL;
            end
            // Row and column to cell address
            S_MUL:
            begin
                addr_next  = ADDR_W'(phys_reg) * ADDR_W'(SCREEN_COLS) + ADDR_W'(tgt_col_reg);
                cnt_next   = '0;
                state_next = ret_reg;
            end
            S_PRINT:
            begin
                tgt_line_next = cl_reg;
                tgt_col_next  = col_reg;
                ret_next      = S_PRINT_WR;
                state_next    = S_PHYS;
            end
            S_PRINT_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {attr, pch_reg};
                if ((COL_W + 1)'(col_reg) + 1'b1 >= (COL_W + 1)'(SCREEN_COLS))
                begin
                    col_next   = '0;
                    state_next = S_ADV;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    vo_next    = bot;
                    state_next = S_NEXT;
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = S_PUSH;
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cell_next  = rd_data_reg;
                state_next = S_PUSH;
            end
            S_ADV:
            begin
                lu_next         = adv_lu;
                cl_next         = adv_cl;
                vo_next         = bottom_of(adv_lu);
                base_next       = LINE_W'(base_sum);
                blank_left_next = adv_k + 1'b1;
                state_next      = S_ADV_BLK;
            end
            // Blank the rows freed by dropped lines, then the cursor row
            S_ADV_BLK:
            begin
                if (blank_left_reg == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    tgt_line_next   = (blank_left_reg > 2'd1) ?
                                      LINE_W'(SCROLLBACK_LINES) -
                                      LINE_W'(blank_left_reg - 1'b1) :
                                      cl_reg;
                    tgt_col_next    = '0;
                    blank_left_next = blank_left_reg - 1'b1;
                    ret_next        = S_BLANK;
                    state_next      = S_PHYS;
                end
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_wdata = blank_cell;
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == COL_W'(SCREEN_COLS - 1))
                begin
                    state_next = S_ADV_BLK;
                end
            end
            // Next space of a tab, or finish
            S_NEXT:
            begin
                if (tab_left_reg <= TAB_W'(1))
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    tab_left_next = tab_left_reg - 1'b1;
                    state_next    = S_PRINT;
                end
            end
            S_PUSH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cell_value = cell_reg;
                    rsp_next.cursor_col = col_reg;
                    rsp_next.cursor_row = cl_reg;
                    rsp_next.view_top   = vo_reg;
                    rsp_next.line_count = LINE_W'(lu_reg);
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            col_reg        <= '0;
            cl_reg         <= '0;
            lu_reg         <= LU_W'(1);
            vo_reg         <= '0;
            base_reg       <= '0;
            fg_reg         <= tts_pkg::FG_RESET;
            bg_reg         <= tts_pkg::BG_RESET;
            addr_reg       <= '0;
            ret_reg        <= S_IDLE;
            tab_left_reg   <= '0;
            blank_left_reg <= '0;
            cnt_reg        <= '0;
            sweep_init_reg <= 1'b1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            cl_reg         <= cl_next;
            lu_reg         <= lu_next;
            vo_reg         <= vo_next;
            base_reg       <= base_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            addr_reg       <= addr_next;
            ret_reg        <= ret_next;
            tab_left_reg   <= tab_left_next;
            blank_left_reg <= blank_left_next;
            cnt_reg        <= cnt_next;
            sweep_init_reg <= sweep_init_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tgt_line_reg <= tgt_line_next;
        tgt_col_reg  <= tgt_col_next;
        phys_reg     <= phys_next;
        pch_reg      <= pch_next;
        wcell_reg    <= wcell_next;
        cell_reg     <= cell_next;
        rsp_reg      <= rsp_next;
    end

    // Scrollback store, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

endmodule
